// ===== rtl/pwl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the piecewise linear table interpolator:
// field widths, command and status codes, sequencer states and table entries.
// ----------------------------------------------------------------------------
package pwl_pkg;

	localparam int TEMP_W = 24;
	localparam int VAL_W = 48;
	localparam int CMD_W = 2;
	localparam int STAT_W = 2;

	localparam int DEF_MAX_POINTS = 64;

	localparam int HALF_W = VAL_W / 2;
	localparam int PART_W = HALF_W + TEMP_W;
	localparam int PROD_W = VAL_W + TEMP_W;
	localparam int DIV_STEPS = VAL_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_INIT,
		ST_DIV,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [VAL_W-1:0] dens;
		logic [VAL_W-1:0] cap;
	} entry_t;

endpackage

// ===== rtl/piecewise_linear_table_interp.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Breakpoint table with two value columns and linear interpolation between
// breakpoints, clamped at both ends of the table.
// ----------------------------------------------------------------------------
// The table lives in one synchronous memory of MAX_POINTS entries with a
// registered read. A clear or append beat and a query on an empty table go
// from acceptance straight to the emit state. A query that clamps to the
// first entry passes through the first-entry check, and one that clamps to
// the last entry through the last-entry check as well. An interpolating query
// passes both checks, scans with one memory read per breakpoint, then runs
// the split 24 by 24 bit multipliers (low half, then high half) and restoring
// division for both columns in parallel. One item is in flight at a time; an
// output register holds a finished result so the next beat can be accepted.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp
	import pwl_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [TEMP_W-1:0]        temperature,
	input  logic signed [VAL_W-1:0]  density_value,
	input  logic signed [VAL_W-1:0]  heat_capacity_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  density,
	output logic signed [VAL_W-1:0]  heat_capacity,
	output logic [STAT_W-1:0]        status
);

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	entry_t mem [MAX_POINTS];
	entry_t rd_data_q;
	entry_t wr_entry;
	entry_t prev_q;
	logic [ADDR_W-1:0] rd_addr;
	logic mem_we;

	logic [CNT_W-1:0] count_q;
	logic [ADDR_W-1:0] last_q;
	logic [ADDR_W-1:0] idx_q;
	logic [TEMP_W-1:0] t_q;
	logic [TEMP_W-1:0] dt_q;
	logic [TEMP_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;

	logic [1:0] neg_q;
	logic [1:0][VAL_W-1:0] v0_q;
	logic [1:0][VAL_W-1:0] mag_q;
	logic [1:0][PART_W-1:0] plo_q;
	logic [1:0][PART_W-1:0] phi_q;
	logic [1:0][TEMP_W-1:0] rem_q;
	logic [1:0][VAL_W-1:0] quo_q;
	logic [1:0][VAL_W-1:0] res_q;
	logic [STAT_W-1:0] res_stat_q;

	logic out_valid_q;
	logic [VAL_W-1:0] density_q;
	logic [VAL_W-1:0] heat_capacity_q;
	logic [STAT_W-1:0] status_q;

	logic accept;
	logic out_free;
	logic full;
	logic t_le_cur;
	logic scan_hit;

	logic [1:0][VAL_W-1:0] cur_v;
	logic [1:0][VAL_W-1:0] prv_v;
	logic [1:0][VAL_W:0] dv;
	logic [1:0][VAL_W:0] dv_neg;
	logic [1:0][VAL_W-1:0] mag_c;
	logic [1:0][PROD_W-1:0] prod_c;
	logic [1:0][TEMP_W:0] trial;
	logic [1:0] ge;
	logic [1:0][TEMP_W-1:0] rem_nx;
	logic [1:0][VAL_W-1:0] quo_nx;
	logic [1:0][VAL_W-1:0] fin_c;

	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full = (count_q == CNT_W'(MAX_POINTS));
	assign t_le_cur = (t_q <= rd_data_q.temp);
	assign scan_hit = t_le_cur || (idx_q == last_q);

	assign mem_we = accept && (command == CMD_APPEND) && !full;
	assign wr_entry = '{temp: temperature, dens: density_value, cap: heat_capacity_value};

	assign out_valid = out_valid_q;
	assign density = density_q;
	assign heat_capacity = heat_capacity_q;
	assign status = status_q;

	always_comb begin
		cur_v[0] = rd_data_q.dens;
		cur_v[1] = rd_data_q.cap;
		prv_v[0] = prev_q.dens;
		prv_v[1] = prev_q.cap;
		for (int c = 0; c < 2; c++) begin
			dv[c] = {cur_v[c][VAL_W-1], cur_v[c]} - {prv_v[c][VAL_W-1], prv_v[c]};
			dv_neg[c] = (VAL_W + 1)'(0) - dv[c];
			mag_c[c] = dv[c][VAL_W] ? dv_neg[c][VAL_W-1:0] : dv[c][VAL_W-1:0];
			prod_c[c] = {phi_q[c], {HALF_W{1'b0}}} + PROD_W'(plo_q[c]);
			trial[c] = {rem_q[c], quo_q[c][VAL_W-1]};
			ge[c] = (trial[c] >= {1'b0, den_q});
			rem_nx[c] = ge[c] ? TEMP_W'(trial[c] - {1'b0, den_q}) : trial[c][TEMP_W-1:0];
			quo_nx[c] = {quo_q[c][VAL_W-2:0], ge[c]};
			fin_c[c] = neg_q[c] ? (v0_q[c] - quo_q[c]) : (v0_q[c] + quo_q[c]);
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == CMD_QUERY && count_q != '0) begin
						state_d = ST_FIRST;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_FIRST: begin
				rd_addr = last_q;
				state_d = t_le_cur ? ST_EMIT : ST_LAST;
			end
			ST_LAST: begin
				rd_addr = ADDR_W'(1);
				state_d = (t_q >= rd_data_q.temp) ? ST_EMIT : ST_SCAN;
			end
			ST_SCAN: begin
				rd_addr = idx_q + ADDR_W'(1);
				if (scan_hit) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (command == CMD_CLEAR) begin
				count_q <= '0;
			end else if (command == CMD_APPEND && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[ADDR_W-1:0]] <= wr_entry;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					t_q <= temperature;
					last_q <= ADDR_W'(count_q - CNT_W'(1));
					idx_q <= ADDR_W'(1);
					res_q <= '0;
					if (command == CMD_APPEND && full) begin
						res_stat_q <= STAT_FULL;
					end else if (command == CMD_QUERY && count_q == '0) begin
						res_stat_q <= STAT_EMPTY;
					end else begin
						res_stat_q <= STAT_OK;
					end
				end
			end
			ST_FIRST: begin
				prev_q <= rd_data_q;
				if (t_le_cur) begin
					res_q[0] <= rd_data_q.dens;
					res_q[1] <= rd_data_q.cap;
				end
			end
			ST_LAST: begin
				if (t_q >= rd_data_q.temp) begin
					res_q[0] <= rd_data_q.dens;
					res_q[1] <= rd_data_q.cap;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					dt_q <= t_q - prev_q.temp;
					den_q <= rd_data_q.temp - prev_q.temp;
					for (int c = 0; c < 2; c++) begin
						v0_q[c] <= prv_v[c];
						neg_q[c] <= dv[c][VAL_W];
						mag_q[c] <= mag_c[c];
					end
				end else begin
					prev_q <= rd_data_q;
					idx_q <= idx_q + ADDR_W'(1);
				end
			end
			ST_MUL_LO: begin
				for (int c = 0; c < 2; c++) begin
					plo_q[c] <= PART_W'(mag_q[c][HALF_W-1:0]) * PART_W'(dt_q);
				end
			end
			ST_MUL_HI: begin
				for (int c = 0; c < 2; c++) begin
					phi_q[c] <= PART_W'(mag_q[c][VAL_W-1:HALF_W]) * PART_W'(dt_q);
				end
			end
			ST_DIV_INIT: begin
				step_q <= '0;
				for (int c = 0; c < 2; c++) begin
					rem_q[c] <= prod_c[c][PROD_W-1:VAL_W];
					quo_q[c] <= prod_c[c][VAL_W-1:0];
				end
			end
			ST_DIV: begin
				step_q <= step_q + STEP_W'(1);
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			ST_FINISH: begin
				res_q <= fin_c;
			end
			ST_EMIT: begin
				if (out_free) begin
					density_q <= res_q[0];
					heat_capacity_q <= res_q[1];
					status_q <= res_stat_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
